// File: rtl/tesl_pkg.sv
// Shared widths, types and helpers for the triangle element stiffness/load block.
package tesl_pkg;

  // Number formats
  localparam int COORD_W          = 16;
  localparam int CFG_W            = 16;
  localparam int RES_W            = 32;
  localparam int COORD_FRAC_BITS  = 8;
  localparam int RESULT_FRAC_BITS = 16;

  // Stiffness numerator is scaled by 2^(RESULT_FRAC_BITS-13): Q4.12 weights and Q8.8 gradients
  localparam int STIFF_SHIFT = RESULT_FRAC_BITS - 13;
  // Load entry divisor: 24 scaled to the result format
  localparam int LOAD_SHIFT  = 3 * COORD_FRAC_BITS - RESULT_FRAC_BITS;

  // Internal widths
  localparam int EDGE_W  = COORD_W + 1;          // coordinate differences
  localparam int PROD_W  = 2 * EDGE_W - 1;       // edge products
  localparam int DET_W   = PROD_W + 1;           // signed determinant
  localparam int ADET_W  = DET_W - 1;            // |det|
  localparam int S_W     = COORD_W + 2;          // 2*f_i + f_j + f_k
  localparam int DV_W    = CFG_W + EDGE_W;       // D*v component
  localparam int NP_W    = EDGE_W + DV_W - 1;    // v_j * (D v_i) product
  localparam int NS_W    = NP_W + 1;             // stiffness numerator
  localparam int MAG_W   = NS_W;
  localparam int P_W     = ADET_W + S_W;         // |det| * |s|
  localparam int NUM_W   = MAG_W + STIFF_SHIFT;  // divider numerator
  localparam int DEN_W   = ADET_W;               // divider denominator
  localparam int NN_W    = NUM_W + 2;            // 2*num + den
  localparam int REM_W   = DEN_W + 1;            // 2*den, remainder
  localparam int Q_W     = 32;                   // quotient bits
  localparam int DIV_STAGES = Q_W / 2;           // two quotient bits per stage
  localparam int LANE_LAT   = DIV_STAGES + 1;

  localparam logic [DEN_W-1:0] LOAD_DEN = DEN_W'(24) << LOAD_SHIFT;

  // Configuration register indexes
  localparam logic [1:0] REG_DIFF_XX = 2'd0;
  localparam logic [1:0] REG_DIFF_XY = 2'd1;
  localparam logic [1:0] REG_DIFF_YX = 2'd2;
  localparam logic [1:0] REG_DIFF_YY = 2'd3;

  localparam logic [CFG_W-1:0] DIFF_ONE = CFG_W'(4096);

  typedef logic signed [EDGE_W-1:0] edge_t;
  typedef logic signed [S_W-1:0]    ssum_t;

  // Element record passed from front to back
  typedef struct packed {
    logic signed [DET_W-1:0] det;
    edge_t vx0;
    edge_t vy0;
    edge_t vx1;
    edge_t vy1;
    edge_t vx2;
    edge_t vy2;
    ssum_t s0;
    ssum_t s1;
    ssum_t s2;
  } tesl_elem_t;

  // Row bookkeeping alongside the divider lanes
  typedef struct packed {
    logic       v;
    logic [1:0] row;
    logic       degen;
  } tesl_sb_t;

  // One finished row
  typedef struct packed {
    logic [1:0]       row;
    logic [RES_W-1:0] stiff0;
    logic [RES_W-1:0] stiff1;
    logic [RES_W-1:0] stiff2;
    logic [RES_W-1:0] load;
    logic             last;
    logic             degen;
    logic             clip;
  } tesl_res_t;

  // One restoring division step: returns {quotient bit, new remainder}
  function automatic logic [REM_W:0] div_step(input logic [REM_W-1:0] rem,
                                              input logic             b,
                                              input logic [REM_W-1:0] d);
    logic [REM_W:0] t;
    logic [REM_W:0] diff;
    t    = {rem, b};
    diff = t - {1'b0, d};
    if (t >= {1'b0, d}) begin
      return {1'b1, diff[REM_W-1:0]};
    end
    return {1'b0, t[REM_W-1:0]};
  endfunction

endpackage

// File: rtl/tesl_front.sv
// Front end: accepts triangles, forms gradients, determinant and source sums, queues elements.
module tesl_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  logic signed [15:0]  in_x_vertex0,
  input  logic signed [15:0]  in_y_vertex0,
  input  logic signed [15:0]  in_x_vertex1,
  input  logic signed [15:0]  in_y_vertex1,
  input  logic signed [15:0]  in_x_vertex2,
  input  logic signed [15:0]  in_y_vertex2,
  input  logic signed [15:0]  in_source_at_vertex0,
  input  logic signed [15:0]  in_source_at_vertex1,
  input  logic signed [15:0]  in_source_at_vertex2,
  input  logic                q_pop,
  output logic                q_empty,
  output tesl_pkg::tesl_elem_t q_head
);

  localparam int Q_DEPTH = 4;

  logic en;
  logic v1_r, v2_r;
  tesl_pkg::edge_t vx0_r, vy0_r, vx1_r, vy1_r, vx2_r, vy2_r;
  tesl_pkg::ssum_t s0_r, s1_r, s2_r;
  tesl_pkg::edge_t f2_vx0_r, f2_vy0_r, f2_vx1_r, f2_vy1_r, f2_vx2_r, f2_vy2_r;
  tesl_pkg::ssum_t f2_s0_r, f2_s1_r, f2_s2_r;
  logic signed [tesl_pkg::PROD_W-1:0] pa_r, pb_r, pa_nxt, pb_nxt;
  tesl_pkg::ssum_t s0_nxt, s1_nxt, s2_nxt;

  tesl_pkg::tesl_elem_t q_mem_r [Q_DEPTH];
  logic [1:0] wr_ptr_r, rd_ptr_r;
  logic [2:0] cnt_r;
  logic       q_full, q_push;
  tesl_pkg::tesl_elem_t push_elem;

  // whole front stalls when the last stage cannot enter the queue
  assign q_full  = (cnt_r == 3'(Q_DEPTH));
  assign q_empty = (cnt_r == 3'd0);
  assign en      = !(v2_r && q_full);
  assign in_full = !en;
  assign q_push  = v2_r && en;

  // source sums 2*f_i + f_j + f_k
  assign s0_nxt = {in_source_at_vertex0[15], in_source_at_vertex0, 1'b0}
                + {{2{in_source_at_vertex1[15]}}, in_source_at_vertex1}
                + {{2{in_source_at_vertex2[15]}}, in_source_at_vertex2};
  assign s1_nxt = {in_source_at_vertex1[15], in_source_at_vertex1, 1'b0}
                + {{2{in_source_at_vertex2[15]}}, in_source_at_vertex2}
                + {{2{in_source_at_vertex0[15]}}, in_source_at_vertex0};
  assign s2_nxt = {in_source_at_vertex2[15], in_source_at_vertex2, 1'b0}
                + {{2{in_source_at_vertex0[15]}}, in_source_at_vertex0}
                + {{2{in_source_at_vertex1[15]}}, in_source_at_vertex1};

  // stage 1: scaled gradients (edge differences)
  always_ff @(posedge clk) begin
    if (en) begin
      vx0_r <= {in_y_vertex1[15], in_y_vertex1} - {in_y_vertex2[15], in_y_vertex2};
      vy0_r <= {in_x_vertex2[15], in_x_vertex2} - {in_x_vertex1[15], in_x_vertex1};
      vx1_r <= {in_y_vertex2[15], in_y_vertex2} - {in_y_vertex0[15], in_y_vertex0};
      vy1_r <= {in_x_vertex0[15], in_x_vertex0} - {in_x_vertex2[15], in_x_vertex2};
      vx2_r <= {in_y_vertex0[15], in_y_vertex0} - {in_y_vertex1[15], in_y_vertex1};
      vy2_r <= {in_x_vertex1[15], in_x_vertex1} - {in_x_vertex0[15], in_x_vertex0};
      s0_r  <= s0_nxt;
      s1_r  <= s1_nxt;
      s2_r  <= s2_nxt;
    end
  end

  // stage 2: det = vy2*vx1 - vy1*vx2
  assign pa_nxt = vy2_r * vx1_r;
  assign pb_nxt = vy1_r * vx2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      pa_r     <= pa_nxt;
      pb_r     <= pb_nxt;
      f2_vx0_r <= vx0_r;
      f2_vy0_r <= vy0_r;
      f2_vx1_r <= vx1_r;
      f2_vy1_r <= vy1_r;
      f2_vx2_r <= vx2_r;
      f2_vy2_r <= vy2_r;
      f2_s0_r  <= s0_r;
      f2_s1_r  <= s1_r;
      f2_s2_r  <= s2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_push;
      v2_r <= v1_r;
    end
  end

  always_comb begin
    push_elem.det = {pa_r[tesl_pkg::PROD_W-1], pa_r} - {pb_r[tesl_pkg::PROD_W-1], pb_r};
    push_elem.vx0 = f2_vx0_r;
    push_elem.vy0 = f2_vy0_r;
    push_elem.vx1 = f2_vx1_r;
    push_elem.vy1 = f2_vy1_r;
    push_elem.vx2 = f2_vx2_r;
    push_elem.vy2 = f2_vy2_r;
    push_elem.s0  = f2_s0_r;
    push_elem.s1  = f2_s1_r;
    push_elem.s2  = f2_s2_r;
  end

  // element queue
  always_ff @(posedge clk) begin
    if (q_push) begin
      q_mem_r[wr_ptr_r] <= push_elem;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 2'd0;
      rd_ptr_r <= 2'd0;
      cnt_r    <= 3'd0;
    end else begin
      if (q_push) wr_ptr_r <= wr_ptr_r + 2'd1;
      if (q_pop)  rd_ptr_r <= rd_ptr_r + 2'd1;
      cnt_r <= cnt_r + 3'(q_push) - 3'(q_pop);
    end
  end

  assign q_head = q_mem_r[rd_ptr_r];

endmodule

// File: rtl/tesl_div.sv
// Divider lane: rounded, saturated quotient, two quotient bits per pipeline stage.
module tesl_div (
  input  logic                          clk,
  input  logic                          en,
  input  logic                          in_neg,
  input  logic [tesl_pkg::NUM_W-1:0]    in_num,
  input  logic [tesl_pkg::DEN_W-1:0]    in_den,
  output logic [tesl_pkg::RES_W-1:0]    res_val,
  output logic                          res_clip
);

  localparam int NS = tesl_pkg::DIV_STAGES;
  localparam int RW = tesl_pkg::REM_W;
  localparam int QW = tesl_pkg::Q_W;

  logic [tesl_pkg::NN_W-1:0] n0_r;
  logic [RW-1:0]             d0_r;
  logic                      neg0_r;

  logic [RW-1:0] rem_r  [NS];
  logic [QW-1:0] low_r  [NS];
  logic [QW-1:0] q_r    [NS];
  logic [RW-1:0] d_r    [NS];
  logic          neg_r  [NS];
  logic          ovf_r  [NS];

  // rounding: floor((2*num + den) / (2*den))
  always_ff @(posedge clk) begin
    if (en) begin
      n0_r   <= tesl_pkg::NN_W'({in_num, 1'b0}) + tesl_pkg::NN_W'(in_den);
      d0_r   <= {in_den, 1'b0};
      neg0_r <= in_neg;
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic [RW-1:0] rem_in;
    logic [QW-1:0] low_in;
    logic [QW-1:0] q_in;
    logic [RW-1:0] d_in;
    logic          neg_in;
    logic          ovf_in;
    logic [RW:0]   st_a, st_b;

    if (k == 0) begin : g_first
      assign rem_in = RW'(n0_r[tesl_pkg::NN_W-1:QW]);
      assign low_in = n0_r[QW-1:0];
      assign q_in   = '0;
      assign d_in   = d0_r;
      assign neg_in = neg0_r;
      // quotient reaches 2^32 exactly when the upper numerator part is not below D
      assign ovf_in = (RW'(n0_r[tesl_pkg::NN_W-1:QW]) >= d0_r);
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign low_in = low_r[k-1];
      assign q_in   = q_r[k-1];
      assign d_in   = d_r[k-1];
      assign neg_in = neg_r[k-1];
      assign ovf_in = ovf_r[k-1];
    end

    assign st_a = tesl_pkg::div_step(rem_in, low_in[QW-1], d_in);
    assign st_b = tesl_pkg::div_step(st_a[RW-1:0], low_in[QW-2], d_in);

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= st_b[RW-1:0];
        low_r[k] <= {low_in[QW-3:0], 2'b00};
        q_r[k]   <= {q_in[QW-3:0], st_a[RW], st_b[RW]};
        d_r[k]   <= d_in;
        neg_r[k] <= neg_in;
        ovf_r[k] <= ovf_in;
      end
    end
  end

  // saturate and apply sign
  logic [QW-1:0] qf;
  assign qf = q_r[NS-1];

  always_comb begin
    res_clip = 1'b0;
    res_val  = qf;
    if (!neg_r[NS-1]) begin
      if (ovf_r[NS-1] || qf[QW-1]) begin
        res_clip = 1'b1;
        res_val  = {1'b0, {(QW-1){1'b1}}};
      end
    end else begin
      if (ovf_r[NS-1] || (qf[QW-1] && (|qf[QW-2:0]))) begin
        res_clip = 1'b1;
        res_val  = {1'b1, {(QW-1){1'b0}}};
      end else begin
        res_val = -qf;
      end
    end
  end

endmodule

// File: rtl/tesl_back.sv
// Back end: row sequencer, diffusion products, numerators and four divider lanes.
module tesl_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        adv,
  input  logic                        q_empty,
  input  tesl_pkg::tesl_elem_t        q_head,
  output logic                        q_pop,
  input  logic signed [15:0]          diff_xx,
  input  logic signed [15:0]          diff_xy,
  input  logic signed [15:0]          diff_yx,
  input  logic signed [15:0]          diff_yy,
  output logic                        res_valid,
  output tesl_pkg::tesl_res_t         res
);

  localparam int LAT = tesl_pkg::LANE_LAT;

  logic       issue;
  logic [1:0] row_r;

  // issue stage selection
  tesl_pkg::edge_t vxi_sel, vyi_sel;
  tesl_pkg::ssum_t s_sel;
  logic [tesl_pkg::ADET_W-1:0] adet_sel;
  logic [tesl_pkg::DET_W-1:0]  det_neg;

  // stage 1
  logic b1_v_r;
  logic [1:0] b1_row_r;
  logic b1_degen_r;
  logic [tesl_pkg::ADET_W-1:0] b1_adet_r;
  tesl_pkg::edge_t b1_vx0_r, b1_vy0_r, b1_vx1_r, b1_vy1_r, b1_vx2_r, b1_vy2_r;
  tesl_pkg::edge_t b1_vxi_r, b1_vyi_r;
  logic b1_sneg_r;
  logic [tesl_pkg::S_W-1:0] b1_smag_r;

  // stage 2
  logic b2_v_r;
  logic [1:0] b2_row_r;
  logic b2_degen_r;
  logic [tesl_pkg::ADET_W-1:0] b2_adet_r;
  tesl_pkg::edge_t b2_vx0_r, b2_vy0_r, b2_vx1_r, b2_vy1_r, b2_vx2_r, b2_vy2_r;
  logic b2_sneg_r;
  logic signed [tesl_pkg::DV_W-1:0] b2_dvx_r, b2_dvy_r, b2_dvx_nxt, b2_dvy_nxt;
  logic signed [tesl_pkg::DV_W-1:0] m_xx, m_xy, m_yx, m_yy;
  logic [tesl_pkg::P_W-1:0] b2_p_r;

  // stage 3
  logic b3_v_r;
  logic [1:0] b3_row_r;
  logic b3_degen_r;
  logic [tesl_pkg::ADET_W-1:0] b3_adet_r;
  logic b3_sneg_r;
  logic [tesl_pkg::P_W-1:0] b3_p_r;
  logic signed [tesl_pkg::NS_W-1:0] b3_n_r [3];
  logic signed [tesl_pkg::NP_W-1:0] na [3];
  logic signed [tesl_pkg::NP_W-1:0] nb [3];
  tesl_pkg::edge_t vxj [3];
  tesl_pkg::edge_t vyj [3];

  // lanes
  logic [tesl_pkg::RES_W-1:0] lane_val  [4];
  logic                       lane_clip [4];
  tesl_pkg::tesl_sb_t sb_r [LAT];

  assign issue = adv && !q_empty;
  assign q_pop = issue && (row_r == 2'd2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= 2'd0;
    end else if (issue) begin
      row_r <= (row_r == 2'd2) ? 2'd0 : row_r + 2'd1;
    end
  end

  // pick the gradient and source sum of the current row
  always_comb begin
    case (row_r)
      2'd1: begin
        vxi_sel = q_head.vx1;
        vyi_sel = q_head.vy1;
        s_sel   = q_head.s1;
      end
      2'd2: begin
        vxi_sel = q_head.vx2;
        vyi_sel = q_head.vy2;
        s_sel   = q_head.s2;
      end
      default: begin
        vxi_sel = q_head.vx0;
        vyi_sel = q_head.vy0;
        s_sel   = q_head.s0;
      end
    endcase
    det_neg  = -q_head.det;
    adet_sel = q_head.det[tesl_pkg::DET_W-1] ? det_neg[tesl_pkg::ADET_W-1:0]
                                             : q_head.det[tesl_pkg::ADET_W-1:0];
  end

  // stage 1: capture row operands
  always_ff @(posedge clk) begin
    if (adv) begin
      b1_row_r   <= row_r;
      b1_degen_r <= (q_head.det == '0);
      b1_adet_r  <= adet_sel;
      b1_vx0_r   <= q_head.vx0;
      b1_vy0_r   <= q_head.vy0;
      b1_vx1_r   <= q_head.vx1;
      b1_vy1_r   <= q_head.vy1;
      b1_vx2_r   <= q_head.vx2;
      b1_vy2_r   <= q_head.vy2;
      b1_vxi_r   <= vxi_sel;
      b1_vyi_r   <= vyi_sel;
      b1_sneg_r  <= s_sel[tesl_pkg::S_W-1];
      b1_smag_r  <= s_sel[tesl_pkg::S_W-1] ? -s_sel : s_sel;
    end
  end

  // stage 2: D * v_i and |det| * |s|
  assign m_xx = diff_xx * b1_vxi_r;
  assign m_xy = diff_xy * b1_vyi_r;
  assign m_yx = diff_yx * b1_vxi_r;
  assign m_yy = diff_yy * b1_vyi_r;
  assign b2_dvx_nxt = m_xx + m_xy;
  assign b2_dvy_nxt = m_yx + m_yy;

  always_ff @(posedge clk) begin
    if (adv) begin
      b2_row_r   <= b1_row_r;
      b2_degen_r <= b1_degen_r;
      b2_adet_r  <= b1_adet_r;
      b2_vx0_r   <= b1_vx0_r;
      b2_vy0_r   <= b1_vy0_r;
      b2_vx1_r   <= b1_vx1_r;
      b2_vy1_r   <= b1_vy1_r;
      b2_vx2_r   <= b1_vx2_r;
      b2_vy2_r   <= b1_vy2_r;
      b2_sneg_r  <= b1_sneg_r;
      b2_dvx_r   <= b2_dvx_nxt;
      b2_dvy_r   <= b2_dvy_nxt;
      b2_p_r     <= tesl_pkg::P_W'(b1_adet_r) * tesl_pkg::P_W'(b1_smag_r);
    end
  end

  // stage 3: numerators v_j . (D v_i)
  assign vxj[0] = b2_vx0_r;
  assign vyj[0] = b2_vy0_r;
  assign vxj[1] = b2_vx1_r;
  assign vyj[1] = b2_vy1_r;
  assign vxj[2] = b2_vx2_r;
  assign vyj[2] = b2_vy2_r;

  for (genvar j = 0; j < 3; j++) begin : g_num
    assign na[j] = vxj[j] * b2_dvx_r;
    assign nb[j] = vyj[j] * b2_dvy_r;
    always_ff @(posedge clk) begin
      if (adv) begin
        b3_n_r[j] <= {na[j][tesl_pkg::NP_W-1], na[j]} + {nb[j][tesl_pkg::NP_W-1], nb[j]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b3_row_r   <= b2_row_r;
      b3_degen_r <= b2_degen_r;
      b3_adet_r  <= b2_adet_r;
      b3_sneg_r  <= b2_sneg_r;
      b3_p_r     <= b2_p_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r <= 1'b0;
      b2_v_r <= 1'b0;
      b3_v_r <= 1'b0;
    end else if (adv) begin
      b1_v_r <= issue;
      b2_v_r <= b1_v_r;
      b3_v_r <= b2_v_r;
    end
  end

  // stiffness lanes
  for (genvar j = 0; j < 3; j++) begin : g_lane
    logic                          neg;
    logic [tesl_pkg::NS_W-1:0]     nneg;
    logic [tesl_pkg::MAG_W-1:0]    mag;
    assign neg  = b3_n_r[j][tesl_pkg::NS_W-1];
    assign nneg = -b3_n_r[j];
    assign mag  = neg ? nneg : b3_n_r[j];
    tesl_div u_div (
      .clk      (clk),
      .en       (adv),
      .in_neg   (neg),
      .in_num   (tesl_pkg::NUM_W'(mag) << tesl_pkg::STIFF_SHIFT),
      .in_den   (b3_adet_r),
      .res_val  (lane_val[j]),
      .res_clip (lane_clip[j])
    );
  end

  // load lane: divide by 24 in the result scale
  tesl_div u_div_load (
    .clk      (clk),
    .en       (adv),
    .in_neg   (b3_sneg_r),
    .in_num   (tesl_pkg::NUM_W'(b3_p_r)),
    .in_den   (tesl_pkg::LOAD_DEN),
    .res_val  (lane_val[3]),
    .res_clip (lane_clip[3])
  );

  // row bookkeeping travels beside the lanes
  for (genvar k = 0; k < LAT; k++) begin : g_sb
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sb_r[k].v <= 1'b0;
      end else if (adv) begin
        if (k == 0) begin
          sb_r[k].v <= b3_v_r;
        end else begin
          sb_r[k].v <= sb_r[k-1].v;
        end
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        if (k == 0) begin
          sb_r[k].row   <= b3_row_r;
          sb_r[k].degen <= b3_degen_r;
        end else begin
          sb_r[k].row   <= sb_r[k-1].row;
          sb_r[k].degen <= sb_r[k-1].degen;
        end
      end
    end
  end

  // assemble row; degenerate elements give zeros
  always_comb begin
    res_valid = sb_r[LAT-1].v;
    res.row   = sb_r[LAT-1].row;
    res.last  = (sb_r[LAT-1].row == 2'd2);
    res.degen = sb_r[LAT-1].degen;
    if (sb_r[LAT-1].degen) begin
      res.stiff0 = '0;
      res.stiff1 = '0;
      res.stiff2 = '0;
      res.load   = '0;
      res.clip   = 1'b0;
    end else begin
      res.stiff0 = lane_val[0];
      res.stiff1 = lane_val[1];
      res.stiff2 = lane_val[2];
      res.load   = lane_val[3];
      res.clip   = lane_clip[0] | lane_clip[1] | lane_clip[2] | lane_clip[3];
    end
  end

endmodule

// File: rtl/triangle_element_stiffness_load.sv
// Top level: P1 triangle element stiffness rows and load entries with result queue.
//
//  channel  | handshake          | payload
//  ---------+--------------------+----------------------------------------------
//  in       | in_push / in_full  | three vertices, three source values (Q8.8)
//  out      | out_pop / out_empty| row, three stiffness entries, load, flags
//  cfg      | cfg_we             | cfg_index, cfg_wdata (diffusion matrix Q4.12)
//
// The back end issues one row per cycle, three per element, while an element is queued
// and the result queue has room. From accept to the first row an element passes two front
// stages, the element queue, three back-end stages, 17-stage divider lanes, result queue.
// Reset (rst_n low, synchronous) empties both queues and restores the identity matrix.
// A full result queue freezes the back end; the element queue then fills and raises in_full.
module triangle_element_stiffness_load (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic signed [15:0] in_x_vertex0,
  input  logic signed [15:0] in_y_vertex0,
  input  logic signed [15:0] in_x_vertex1,
  input  logic signed [15:0] in_y_vertex1,
  input  logic signed [15:0] in_x_vertex2,
  input  logic signed [15:0] in_y_vertex2,
  input  logic signed [15:0] in_source_at_vertex0,
  input  logic signed [15:0] in_source_at_vertex1,
  input  logic signed [15:0] in_source_at_vertex2,
  output logic               out_empty,
  input  logic               out_pop,
  output logic [1:0]         out_row_number,
  output logic signed [31:0] out_stiff_col0,
  output logic signed [31:0] out_stiff_col1,
  output logic signed [31:0] out_stiff_col2,
  output logic signed [31:0] out_load_entry,
  output logic               out_last_row,
  output logic               out_degenerate,
  output logic               out_clipped,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_wdata
);

  logic signed [15:0] diff_xx_r, diff_xy_r, diff_yx_r, diff_yy_r;
  logic                 q_empty, q_pop;
  tesl_pkg::tesl_elem_t q_head;
  logic                 adv;
  logic                 res_valid;
  tesl_pkg::tesl_res_t  res;

  tesl_pkg::tesl_res_t  oq_mem_r [2];
  logic                 oq_wr_r, oq_rd_r;
  logic [1:0]           oq_cnt_r;
  logic                 oq_push, oq_pop;
  tesl_pkg::tesl_res_t  oq_head;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      diff_xx_r <= tesl_pkg::DIFF_ONE;
      diff_xy_r <= '0;
      diff_yx_r <= '0;
      diff_yy_r <= tesl_pkg::DIFF_ONE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tesl_pkg::REG_DIFF_XX: diff_xx_r <= cfg_wdata;
        tesl_pkg::REG_DIFF_XY: diff_xy_r <= cfg_wdata;
        tesl_pkg::REG_DIFF_YX: diff_yx_r <= cfg_wdata;
        tesl_pkg::REG_DIFF_YY: diff_yy_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  tesl_front u_front (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_push              (in_push),
    .in_full              (in_full),
    .in_x_vertex0         (in_x_vertex0),
    .in_y_vertex0         (in_y_vertex0),
    .in_x_vertex1         (in_x_vertex1),
    .in_y_vertex1         (in_y_vertex1),
    .in_x_vertex2         (in_x_vertex2),
    .in_y_vertex2         (in_y_vertex2),
    .in_source_at_vertex0 (in_source_at_vertex0),
    .in_source_at_vertex1 (in_source_at_vertex1),
    .in_source_at_vertex2 (in_source_at_vertex2),
    .q_pop                (q_pop),
    .q_empty              (q_empty),
    .q_head               (q_head)
  );

  tesl_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .diff_xx   (diff_xx_r),
    .diff_xy   (diff_xy_r),
    .diff_yx   (diff_yx_r),
    .diff_yy   (diff_yy_r),
    .res_valid (res_valid),
    .res       (res)
  );

  // two-entry result queue; back end advances while it has room
  assign adv     = (oq_cnt_r != 2'd2);
  assign oq_push = res_valid && adv;
  assign oq_pop  = out_pop && !out_empty;

  always_ff @(posedge clk) begin
    if (oq_push) begin
      oq_mem_r[oq_wr_r] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wr_r  <= 1'b0;
      oq_rd_r  <= 1'b0;
      oq_cnt_r <= 2'd0;
    end else begin
      if (oq_push) oq_wr_r <= !oq_wr_r;
      if (oq_pop)  oq_rd_r <= !oq_rd_r;
      oq_cnt_r <= oq_cnt_r + 2'(oq_push) - 2'(oq_pop);
    end
  end

  assign oq_head        = oq_mem_r[oq_rd_r];
  assign out_empty      = (oq_cnt_r == 2'd0);
  assign out_row_number = oq_head.row;
  assign out_stiff_col0 = oq_head.stiff0;
  assign out_stiff_col1 = oq_head.stiff1;
  assign out_stiff_col2 = oq_head.stiff2;
  assign out_load_entry = oq_head.load;
  assign out_last_row   = oq_head.last;
  assign out_degenerate = oq_head.degen;
  assign out_clipped    = oq_head.clip;

  // checks
  a_last_matches_row: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_last_row == (out_row_number == 2'd2)))
    else $error("last_row flag disagrees with row number");

  a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_row_number != 2'd3))
    else $error("row number out of range");

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_degenerate) |-> (out_stiff_col0 == 32'sd0 && out_stiff_col1 == 32'sd0
      && out_stiff_col2 == 32'sd0 && out_load_entry == 32'sd0 && !out_clipped))
    else $error("degenerate row carries nonzero entries");

  a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (oq_cnt_r == 2'd2) |-> !oq_push)
    else $error("result queue overflow");

endmodule
